### design/ppm_fd_pkg.sv
// ppm_fd_pkg: types, codes and reset constants for the ppm frame decoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ppm_fd_pkg;

	localparam int CHANNELS_DEFAULT = 16;

	localparam logic [15:0] PULSE_MAX_RST  = 16'd510;
	localparam logic [15:0] SYNC_MIN_RST   = 16'd1910;
	localparam logic [11:0] VALUE_LOW_RST  = 12'd810;
	localparam logic [11:0] VALUE_HIGH_RST = 12'd2210;
	localparam logic [15:0] TIMEOUT_MS_RST = 16'd500;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PULSE_MAX  = 3'd0,
		REG_SYNC_MIN   = 3'd1,
		REG_VALUE_LOW  = 3'd2,
		REG_VALUE_HIGH = 3'd3,
		REG_TIMEOUT_MS = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_EDGE = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		logic [15:0] pulse_max;
		logic [15:0] sync_min;
		logic [11:0] value_low;
		logic [11:0] value_high;
		logic [15:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] interval_us;
		logic [3:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic        wrote;
		logic [3:0]  wrote_channel;
		logic [11:0] wrote_value;
		logic        sync_seen;
		logic        receiving;
		logic [11:0] read_value;
	} out_item_t;

endpackage

### design/ppm_fd_cfg.sv
// ppm_fd_cfg: configuration register bank of the ppm frame decoder
// depends on ppm_fd_pkg
`timescale 1ns / 1ps

module ppm_fd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ppm_fd_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [ppm_fd_pkg::CFG_DATA_W-1:0]   wr_data,
	output ppm_fd_pkg::cfg_t                    cfg
);

	ppm_fd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_max  <= ppm_fd_pkg::PULSE_MAX_RST;
			cfg_q.sync_min   <= ppm_fd_pkg::SYNC_MIN_RST;
			cfg_q.value_low  <= ppm_fd_pkg::VALUE_LOW_RST;
			cfg_q.value_high <= ppm_fd_pkg::VALUE_HIGH_RST;
			cfg_q.timeout_ms <= ppm_fd_pkg::TIMEOUT_MS_RST;
		end else if (wr_en) begin
			case (wr_index)
				ppm_fd_pkg::REG_PULSE_MAX:  cfg_q.pulse_max  <= wr_data;
				ppm_fd_pkg::REG_SYNC_MIN:   cfg_q.sync_min   <= wr_data;
				ppm_fd_pkg::REG_VALUE_LOW:  cfg_q.value_low  <= wr_data[11:0];
				ppm_fd_pkg::REG_VALUE_HIGH: cfg_q.value_high <= wr_data[11:0];
				ppm_fd_pkg::REG_TIMEOUT_MS: cfg_q.timeout_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/ppm_fd_decode.sv
// ppm_fd_decode: decoder state (pulse, channel index, link age, channel values)
// and the per-item update logic; depends on ppm_fd_pkg
`timescale 1ns / 1ps

module ppm_fd_decode #(
	parameter int CHANNELS = ppm_fd_pkg::CHANNELS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  ppm_fd_pkg::in_item_t  item,
	input  ppm_fd_pkg::cfg_t      cfg,
	output ppm_fd_pkg::out_item_t result
);

	localparam int IDX_W = $clog2(CHANNELS + 1);

	logic [15:0]      last_pulse_q;
	logic [IDX_W-1:0] channel_index_q;
	logic [15:0]      ms_since_sync_q;
	logic [11:0]      channel_values_q [CHANNELS];

	logic [16:0]      sum;
	logic             is_edge, is_tick, is_read;
	logic             is_pulse, is_sync, is_gap, in_window;
	logic [15:0]      ms_next;
	logic [11:0]      rval;

	assign is_edge   = item.op == ppm_fd_pkg::OP_EDGE;
	assign is_tick   = item.op == ppm_fd_pkg::OP_TICK;
	assign is_read   = item.op == ppm_fd_pkg::OP_READ;
	assign is_pulse  = is_edge && (item.interval_us < cfg.pulse_max);
	assign is_sync   = is_edge && !is_pulse && (item.interval_us > cfg.sync_min);
	assign is_gap    = is_edge && !is_pulse && !is_sync
		&& (channel_index_q < IDX_W'(CHANNELS));
	assign sum       = {1'b0, item.interval_us} + {1'b0, last_pulse_q};
	assign in_window = (sum > {5'b0, cfg.value_low}) && (sum < {5'b0, cfg.value_high});

	always_comb begin
		if (is_sync) begin
			ms_next = '0;
		end else if (is_tick && ms_since_sync_q != 16'hFFFF) begin
			ms_next = ms_since_sync_q + 16'd1;
		end else begin
			ms_next = ms_since_sync_q;
		end
	end

	always_comb begin
		rval = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if ({2'b0, item.read_index} == 6'(i)) begin
				rval = channel_values_q[i];
			end
		end
	end

	always_comb begin
		result.wrote         = is_gap && in_window;
		result.wrote_channel = (is_gap && in_window) ? 4'(channel_index_q) : 4'd0;
		result.wrote_value   = (is_gap && in_window) ? sum[11:0] : 12'd0;
		result.sync_seen     = is_sync;
		result.receiving     = ms_next <= cfg.timeout_ms;
		result.read_value    = is_read ? rval : 12'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pulse_q    <= '0;
			channel_index_q <= '0;
			ms_since_sync_q <= '0;
		end else if (commit) begin
			ms_since_sync_q <= ms_next;
			if (is_pulse) begin
				last_pulse_q <= item.interval_us;
			end
			if (is_sync) begin
				channel_index_q <= '0;
			end else if (is_gap) begin
				channel_index_q <= channel_index_q + IDX_W'(1);
			end
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				channel_values_q[g] <= '0;
			end else if (commit && is_gap && in_window
				&& channel_index_q == IDX_W'(g)) begin
				channel_values_q[g] <= sum[11:0];
			end
		end
	end

endmodule

### design/ppm_fd_pipe.sv
// ppm_fd_pipe: input stage and result register with valid/ready handshake
// depends on ppm_fd_pkg
`timescale 1ns / 1ps

module ppm_fd_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  ppm_fd_pkg::in_item_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output ppm_fd_pkg::out_item_t rsp,
	output ppm_fd_pkg::in_item_t  item_s1,
	output logic                  commit,
	input  ppm_fd_pkg::out_item_t result
);

	logic                  valid_s1;
	ppm_fd_pkg::in_item_t  req_s1;
	logic                  rsp_valid_q;
	ppm_fd_pkg::out_item_t rsp_q;

	assign commit    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (commit) begin
			rsp_q <= result;
		end
	end

	assign item_s1   = req_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/ppm_frame_decoder_core.sv
// ppm_frame_decoder_core: top level of the ppm frame decoder
// depends on ppm_fd_pkg, ppm_fd_cfg, ppm_fd_decode, ppm_fd_pipe
`timescale 1ns / 1ps

// Decodes an RC pulse-position stream from edge-interval, millisecond-tick and
// channel-read items; every item yields exactly one result item. An item is
// registered, then its whole update (one 17-bit add, a few 16-bit compares and
// the channel value register file) runs when the item commits and lands in the
// result register, so one item is taken per clock, stalling only when the result
// register is still held by the consumer. Channel values live in CHANNELS
// flip-flop registers cleared by reset; channels at or beyond sixteen cannot be
// read through the 4-bit index. Configuration writes are meant to be issued only
// while no item is in flight.

module ppm_frame_decoder_core #(
	parameter int CHANNELS = ppm_fd_pkg::CHANNELS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  ppm_fd_pkg::in_item_t                req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output ppm_fd_pkg::out_item_t               rsp,
	input  logic                                wr_en,
	input  logic [ppm_fd_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [ppm_fd_pkg::CFG_DATA_W-1:0]   wr_data
);

	ppm_fd_pkg::cfg_t      cfg;
	ppm_fd_pkg::in_item_t  item_s1;
	ppm_fd_pkg::out_item_t result;
	logic                  commit;

	ppm_fd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ppm_fd_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.item_s1   (item_s1),
		.commit    (commit),
		.result    (result)
	);

	ppm_fd_decode #(
		.CHANNELS (CHANNELS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

endmodule

### design/ppm_fd_checker.sv
// ppm_fd_checker: port-level assertions for ppm_frame_decoder_core
// depends on ppm_fd_pkg; bound to the top level below
`timescale 1ns / 1ps

module ppm_fd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input ppm_fd_pkg::out_item_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	a_wrote_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.wrote |-> !rsp.sync_seen && rsp.read_value == 12'd0
			&& rsp.wrote_value != 12'd0)
		else $error("store item carries sync or read data");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.wrote |-> rsp.wrote_value == 12'd0 && rsp.wrote_channel == 4'd0)
		else $error("store fields set without a store");

	a_sync_recv: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.sync_seen |-> rsp.receiving)
		else $error("link not receiving right after sync");

endmodule

bind ppm_frame_decoder_core ppm_fd_checker u_ppm_fd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
